/* design/dexs_pkg.sv */
package dexs_pkg;

    // Default number of activation ring slots.
    localparam int RING_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int DELAY_W = 10;
    localparam int GAIN_W  = 63;
    localparam int DECAY_W = 33;
    localparam int RLEN_W  = 11;
    localparam int CFG_W   = 3;

    // Signed Q32.32 value.
    typedef logic signed [63:0] t_q;

    localparam t_q Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q Q_MIN = 64'sh8000_0000_0000_0000;

    // Configuration register indexes.
    typedef logic [CFG_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_INPUT_GAIN_X  = 3'd0;
    localparam t_cfg_idx CFG_DECAY_X       = 3'd1;
    localparam t_cfg_idx CFG_INPUT_GAIN_Y  = 3'd2;
    localparam t_cfg_idx CFG_DECAY_Y       = 3'd3;
    localparam t_cfg_idx CFG_REVERSAL      = 3'd4;
    localparam t_cfg_idx CFG_PEAK_NORM     = 3'd5;
    localparam t_cfg_idx CFG_RING_LENGTH   = 3'd6;

    localparam logic [RLEN_W-1:0] RING_LENGTH_RST = 11'd1024;

    // Operation codes of an input beat.
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Request to and response from the shared multiplier.
    typedef struct packed {
        logic start;
        t_q   a;
        t_q   b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_q   result;
    } t_mul_rsp;

    // Saturating Q32.32 addition.
    function automatic t_q add_sat(t_q a, t_q b);
        t_q s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    // Saturating Q32.32 subtraction.
    function automatic t_q sub_sat(t_q a, t_q b);
        t_q s;
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63])) begin
            s = a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

endpackage

/* design/dual_exp_synapse_current_core.sv */
// One dual-exponential synapse in signed Q32.32. A deposit beat adds its weight into the
// activation ring slot delay_slots ahead of the read pointer (modulo the ring length in
// use) and returns nothing; its slot index is folded into the ring by the bit-serial
// remainder unit, one bit a cycle.
// A tick beat reads and clears the slot at the read pointer, updates the two exponential
// states, and returns one beat with the conductance and the current; it runs six dependent
// multiplies through one shared 32x32 multiplier that builds each 64x64 product from four
// partial products. After reset the ring is swept to zero, during which no input beat is
// taken while configuration writes still are. A finished result waits in the output
// register while the next beat is taken.
module dual_exp_synapse_current_core #(
    parameter int RING_DEPTH = dexs_pkg::RING_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [dexs_pkg::DELAY_W-1:0]      i_delay_slots,
    input  dexs_pkg::t_q                      i_weight,
    input  dexs_pkg::t_q                      i_membrane_voltage,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dexs_pkg::t_q                      o_current_increment,
    output dexs_pkg::t_q                      o_conductance,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  dexs_pkg::t_cfg_idx                i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH + 1);
    localparam int DW = ((PW > dexs_pkg::DELAY_W) ? PW : dexs_pkg::DELAY_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DWB,
        S_TCLR,
        S_MSTART,
        S_MWAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_RISE_IN,
        MS_RISE_DECAY,
        MS_COND_IN,
        MS_COND_DECAY,
        MS_NORM,
        MS_DRIVE
    } t_mstep;

    // Configuration registers.
    logic [dexs_pkg::GAIN_W-1:0]  r_input_gain_x;
    logic [dexs_pkg::DECAY_W-1:0] r_decay_x;
    logic [dexs_pkg::GAIN_W-1:0]  r_input_gain_y;
    logic [dexs_pkg::DECAY_W-1:0] r_decay_y;
    dexs_pkg::t_q                 r_reversal_potential;
    logic [dexs_pkg::GAIN_W-1:0]  r_peak_norm;
    logic [dexs_pkg::RLEN_W-1:0]  r_ring_length;

    // Sequencer state.
    t_state        r_state;
    t_mstep        r_mstep;
    logic [PW-1:0] r_read_pointer;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_slot;
    dexs_pkg::t_q  r_weight;
    dexs_pkg::t_q  r_vm;
    dexs_pkg::t_q  r_act;
    dexs_pkg::t_q  r_diff;
    dexs_pkg::t_q  r_part;
    dexs_pkg::t_q  r_x;
    dexs_pkg::t_q  r_y;
    dexs_pkg::t_q  r_g;
    dexs_pkg::t_q  r_cur;
    logic          r_out_valid;
    dexs_pkg::t_q  r_out_cur;
    dexs_pkg::t_q  r_out_g;

    logic [31:0]        w_rl32;
    logic [31:0]        w_len32;
    logic [LW-1:0]      w_len;
    logic [PW-1:0]      w_ptr_use;
    logic [31:0]        w_ptr_next32;
    logic [PW-1:0]      w_ptr_next;
    logic               w_accept;
    logic               w_clear_busy;
    logic               w_rd_en;
    logic [PW-1:0]      w_rd_addr;
    dexs_pkg::t_q       w_rd_data;
    logic               w_wr_en;
    logic [PW-1:0]      w_wr_addr;
    dexs_pkg::t_q       w_wr_data;
    logic               w_rem_start;
    logic [DW-1:0]      w_dividend;
    logic               w_rem_done;
    logic [LW-1:0]      w_rem;
    dexs_pkg::t_mul_req w_mul_req;
    dexs_pkg::t_mul_rsp w_mul_rsp;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain_x       <= '0;
            r_decay_x            <= '0;
            r_input_gain_y       <= '0;
            r_decay_y            <= '0;
            r_reversal_potential <= '0;
            r_peak_norm          <= '0;
            r_ring_length        <= dexs_pkg::RING_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dexs_pkg::CFG_INPUT_GAIN_X: r_input_gain_x <= i_cfg_data[62:0];
                dexs_pkg::CFG_DECAY_X:      r_decay_x      <= i_cfg_data[32:0];
                dexs_pkg::CFG_INPUT_GAIN_Y: r_input_gain_y <= i_cfg_data[62:0];
                dexs_pkg::CFG_DECAY_Y:      r_decay_y      <= i_cfg_data[32:0];
                dexs_pkg::CFG_REVERSAL:     r_reversal_potential <= i_cfg_data;
                dexs_pkg::CFG_PEAK_NORM:    r_peak_norm    <= i_cfg_data[62:0];
                dexs_pkg::CFG_RING_LENGTH:  r_ring_length  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Length in use: zero acts as one, anything above the depth acts as the depth.
    always_comb begin
        w_rl32 = 32'(r_ring_length);
        if (w_rl32 == 32'd0) begin
            w_len32 = 32'd1;
        end else if (w_rl32 > 32'(RING_DEPTH)) begin
            w_len32 = 32'(RING_DEPTH);
        end else begin
            w_len32 = w_rl32;
        end
    end
    assign w_len = w_len32[LW-1:0];

    // A pointer left beyond a shortened ring restarts at slot zero.
    assign w_ptr_use    = (32'(r_read_pointer) < w_len32) ? r_read_pointer : '0;
    assign w_ptr_next32 = 32'(r_ptr) + 32'd1;
    assign w_ptr_next   = (w_ptr_next32 >= w_len32) ? '0 : w_ptr_next32[PW-1:0];

    assign o_in_ready = (r_state == S_IDLE) && !w_clear_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // A deposit starts the slot remainder as soon as it is taken.
    assign w_rem_start = w_accept && (i_operation == dexs_pkg::OP_DEPOSIT);
    assign w_dividend  = DW'(w_ptr_use) + DW'(i_delay_slots);

    // Ring read: the tick slot on accept, the deposit slot once the remainder is ready.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_ptr_use;
        if (w_accept && (i_operation == dexs_pkg::OP_TICK)) begin
            w_rd_en = 1'b1;
        end else if ((r_state == S_MOD) && w_rem_done) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_rem[PW-1:0];
        end
    end

    // Ring write-back: the saturated sum on deposit, zero on tick.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_data = '0;
        case (r_state)
            S_DWB: begin
                w_wr_en   = 1'b1;
                w_wr_data = dexs_pkg::add_sat(w_rd_data, r_weight);
            end
            S_TCLR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_ptr;
            end
            default: ;
        endcase
    end

    // Operands of the shared multiplier for each step of the update.
    always_comb begin
        w_mul_req.start = (r_state == S_MSTART);
        case (r_mstep)
            MS_RISE_IN: begin
                w_mul_req.a = r_act;
                w_mul_req.b = {1'b0, r_input_gain_x};
            end
            MS_RISE_DECAY: begin
                w_mul_req.a = r_x;
                w_mul_req.b = {31'd0, r_decay_x};
            end
            MS_COND_IN: begin
                w_mul_req.a = r_x;
                w_mul_req.b = {1'b0, r_input_gain_y};
            end
            MS_COND_DECAY: begin
                w_mul_req.a = r_y;
                w_mul_req.b = {31'd0, r_decay_y};
            end
            MS_NORM: begin
                w_mul_req.a = r_y;
                w_mul_req.b = {1'b0, r_peak_norm};
            end
            MS_DRIVE: begin
                w_mul_req.a = r_diff;
                w_mul_req.b = r_g;
            end
            default: begin
                w_mul_req.a = '0;
                w_mul_req.b = '0;
            end
        endcase
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_mstep        <= MS_RISE_IN;
            r_read_pointer <= '0;
            r_x            <= '0;
            r_y            <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // The output register empties when its beat is taken, unless it reloads.
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_weight <= i_weight;
                        r_vm     <= i_membrane_voltage;
                        r_ptr    <= w_ptr_use;
                        r_state  <= (i_operation == dexs_pkg::OP_TICK) ? S_TCLR : S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_rem_done) begin
                        r_slot  <= w_rem[PW-1:0];
                        r_state <= S_DWB;
                    end
                end
                S_DWB: begin
                    r_state <= S_IDLE;
                end
                S_TCLR: begin
                    r_act          <= w_rd_data;
                    r_read_pointer <= w_ptr_next;
                    r_diff         <= dexs_pkg::sub_sat(r_vm, r_reversal_potential);
                    r_mstep        <= MS_RISE_IN;
                    r_state        <= S_MSTART;
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mul_rsp.done) begin
                        r_state <= S_MSTART;
                        case (r_mstep)
                            MS_RISE_IN: begin
                                r_part  <= w_mul_rsp.result;
                                r_mstep <= MS_RISE_DECAY;
                            end
                            MS_RISE_DECAY: begin
                                r_x     <= dexs_pkg::add_sat(r_part, w_mul_rsp.result);
                                r_mstep <= MS_COND_IN;
                            end
                            MS_COND_IN: begin
                                r_part  <= w_mul_rsp.result;
                                r_mstep <= MS_COND_DECAY;
                            end
                            MS_COND_DECAY: begin
                                r_y     <= dexs_pkg::add_sat(r_part, w_mul_rsp.result);
                                r_mstep <= MS_NORM;
                            end
                            MS_NORM: begin
                                r_g     <= w_mul_rsp.result;
                                r_mstep <= MS_DRIVE;
                            end
                            MS_DRIVE: begin
                                r_cur   <= w_mul_rsp.result;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_cur   <= r_cur;
                        r_out_g     <= r_g;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_current_increment = r_out_cur;
    assign o_conductance       = r_out_g;

    dexs_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_clear_busy (w_clear_busy),
        .i_rd_en      (w_rd_en),
        .i_rd_addr    (w_rd_addr),
        .o_rd_data    (w_rd_data),
        .i_wr_en      (w_wr_en),
        .i_wr_addr    (w_wr_addr),
        .i_wr_data    (w_wr_data)
    );

    dexs_rem #(
        .DW (DW),
        .LW (LW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_len),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    dexs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // The multiplier answers only the step that is waiting for it.
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_MWAIT))
        else $error("multiplier result arrived outside its wait state");

    // The remainder unit finishes only while a deposit waits for its slot.
    a_rem_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == S_MOD))
        else $error("slot remainder finished outside a deposit");

    // The sequencer never writes the ring during the clearing pass.
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_clear_busy)
        else $error("ring write during clearing pass");

    // The stored read pointer always addresses a real slot.
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_TCLR) |-> (32'(r_read_pointer) < 32'(RING_DEPTH)))
        else $error("read pointer beyond ring depth");

endmodule

/* design/dexs_mul.sv */
module dexs_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dexs_pkg::t_mul_req i_req,
    output dexs_pkg::t_mul_rsp o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_PROD,
        ST_FLUSH,
        ST_NEG,
        ST_SAT
    } t_state;

    t_state         r_state;
    dexs_pkg::t_q   r_a;
    dexs_pkg::t_q   r_b;
    logic [63:0]    r_ua;
    logic [63:0]    r_ub;
    logic           r_neg;
    logic [1:0]     r_idx;
    logic [63:0]    r_prod;
    logic [1:0]     r_pidx;
    logic           r_pvalid;
    logic [127:0]   r_acc;
    logic           r_done;
    dexs_pkg::t_q   r_result;

    logic [31:0]    w_op_a;
    logic [31:0]    w_op_b;
    logic [63:0]    w_mul;
    logic [127:0]   w_shifted;
    logic [32:0]    w_top;
    dexs_pkg::t_q   w_sat;

    // Pick the 32-bit halves of the magnitudes for this partial product.
    assign w_op_a = r_idx[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_op_b = r_idx[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_mul  = w_op_a * w_op_b;

    // Align the registered partial product to its weight.
    always_comb begin
        case (r_pidx)
            2'd0:    w_shifted = {64'd0, r_prod};
            2'd3:    w_shifted = {r_prod, 64'd0};
            default: w_shifted = {32'd0, r_prod, 32'd0};
        endcase
    end

    // Take bits 95:32 of the signed product, saturating when they do not hold it.
    assign w_top = r_acc[127:95];
    assign w_sat = ((&w_top) || !(|w_top)) ? dexs_pkg::t_q'(r_acc[95:32])
                 : (r_acc[127] ? dexs_pkg::Q_MIN : dexs_pkg::Q_MAX);

    // Sequence: magnitudes, four partial products, sign, saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_pvalid <= 1'b0;
            if (r_pvalid) begin
                r_acc <= r_acc + w_shifted;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_state <= ST_MAG;
                    end
                end
                ST_MAG: begin
                    r_ua    <= r_a[63] ? (~r_a + 64'd1) : r_a;
                    r_ub    <= r_b[63] ? (~r_b + 64'd1) : r_b;
                    r_neg   <= r_a[63] ^ r_b[63];
                    r_acc   <= '0;
                    r_idx   <= 2'd0;
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_prod   <= w_mul;
                    r_pidx   <= r_idx;
                    r_pvalid <= 1'b1;
                    r_idx    <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_state <= ST_NEG;
                end
                ST_NEG: begin
                    if (r_neg) begin
                        r_acc <= ~r_acc + 128'd1;
                    end
                    r_state <= ST_SAT;
                end
                ST_SAT: begin
                    r_result <= w_sat;
                    r_done   <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

/* design/dexs_rem.sv */
module dexs_rem #(
    parameter int DW = 11,
    parameter int LW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [LW-1:0] i_divisor,
    output logic          o_done,
    output logic [LW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state        r_state;
    logic [DW-1:0] r_dvd;
    logic [LW-1:0] r_divisor;
    logic [LW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [LW:0]   w_trial;
    logic [LW:0]   w_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_next  = (w_trial >= {1'b0, r_divisor}) ? (w_trial - {1'b0, r_divisor})
                                                   : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_dvd     <= i_dividend;
                        r_divisor <= i_divisor;
                        r_rem     <= '0;
                        r_cnt     <= CW'(DW);
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem <= w_next[LW-1:0];
                    r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* design/dexs_ring.sv */
module dexs_ring #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_clear_busy,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output dexs_pkg::t_q  o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  dexs_pkg::t_q  i_wr_data
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    dexs_pkg::t_q  r_mem [DEPTH];
    dexs_pkg::t_q  r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    dexs_pkg::t_q  w_wdata;

    // Clearing pass after reset, one slot per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // The clearing pass owns the write port while it runs.
    assign w_we    = r_clearing || i_wr_en;
    assign w_waddr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wdata = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clearing;

endmodule

/* test/dual_exp_synapse_current_core_test.sv */
module dual_exp_synapse_current_core_test;

    localparam int             RING_SLOTS   = dexs_pkg::RING_DEPTH_DEF;
    localparam int             ITEM_TAIL    = 100;
    localparam int             PHASE_ITEMS  = 175;
    localparam int unsigned    CYCLE_LIMIT  = 1_000_000;
    localparam dexs_pkg::t_q   ONE_Q        = 64'sh0000_0001_0000_0000;

    typedef logic [dexs_pkg::DELAY_W-1:0] t_delay;

    // One input beat and one result beat.
    typedef struct packed {
        logic         op;
        t_delay       delay;
        dexs_pkg::t_q weight;
        dexs_pkg::t_q vm;
    } t_syn_beat;

    typedef struct packed {
        dexs_pkg::t_q current;
        dexs_pkg::t_q cond;
    } t_syn_out;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Input channel.
    logic         in_valid  = 1'b0;
    logic         in_op     = dexs_pkg::OP_DEPOSIT;
    t_delay       in_delay  = '0;
    dexs_pkg::t_q in_weight = '0;
    dexs_pkg::t_q in_vm     = '0;
    logic         in_ready;

    // Result channel.
    logic         out_valid;
    logic         out_ready = 1'b0;
    dexs_pkg::t_q out_current;
    dexs_pkg::t_q out_cond;

    // Register write channel.
    logic               cfg_valid = 1'b0;
    dexs_pkg::t_cfg_idx cfg_index = dexs_pkg::CFG_INPUT_GAIN_X;
    logic [63:0]        cfg_data  = '0;
    logic               cfg_ready;

    // Beats still to be sent and results still owed by the block.
    t_syn_beat synapse_beats[$];
    t_syn_out  due_currents[$];

    // Shadow copy of the synapse state and its settings.
    dexs_pkg::t_q act_ring[RING_SLOTS];
    int unsigned  rd_ptr;
    dexs_pkg::t_q rise_x;
    dexs_pkg::t_q cond_y;
    dexs_pkg::t_q gain_x;
    dexs_pkg::t_q dec_x;
    dexs_pkg::t_q gain_y;
    dexs_pkg::t_q dec_y;
    dexs_pkg::t_q rev_pot;
    dexs_pkg::t_q norm_g;
    logic [dexs_pkg::RLEN_W-1:0] ring_len;

    int          errors = 0;
    int unsigned cycle_count = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          in_wait = 0;
    int          in_calm = 0;
    int          out_stall = 0;
    int          out_calm = 0;

    dual_exp_synapse_current_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_operation         (in_op),
        .i_delay_slots       (in_delay),
        .i_weight            (in_weight),
        .i_membrane_voltage  (in_vm),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_current_increment (out_current),
        .o_conductance       (out_cond),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturating Q32.32 sum, done one bit wider.
    function automatic dexs_pkg::t_q q_sum(dexs_pkg::t_q a, dexs_pkg::t_q b);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63]) begin
            return s[64] ? dexs_pkg::Q_MIN : dexs_pkg::Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic dexs_pkg::t_q q_diff(dexs_pkg::t_q a, dexs_pkg::t_q b);
        logic signed [64:0] s;
        s = a - b;
        if (s[64] != s[63]) begin
            return s[64] ? dexs_pkg::Q_MIN : dexs_pkg::Q_MAX;
        end
        return s[63:0];
    endfunction

    // Exact product, floored to Q32.32, then saturated.
    function automatic dexs_pkg::t_q q_product(dexs_pkg::t_q a, dexs_pkg::t_q b);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> 32;
        if (p[127:63] != {65{p[63]}}) begin
            return p[127] ? dexs_pkg::Q_MIN : dexs_pkg::Q_MAX;
        end
        return p[63:0];
    endfunction

    // Number of ring slots actually in use.
    function automatic int unsigned ring_span();
        if (ring_len == 0) begin
            return 1;
        end
        if (ring_len > RING_SLOTS) begin
            return RING_SLOTS;
        end
        return 32'(ring_len);
    endfunction

    // Apply one accepted beat to the shadow state and queue the result a tick owes.
    function automatic void advance_synapse(t_syn_beat b);
        int unsigned  span;
        int unsigned  ptr;
        int unsigned  slot;
        dexs_pkg::t_q act;
        t_syn_out     r;
        span = ring_span();
        ptr  = (rd_ptr < span) ? rd_ptr : 0;
        if (b.op == dexs_pkg::OP_DEPOSIT) begin
            slot = (ptr + b.delay) % span;
            act_ring[slot] = q_sum(act_ring[slot], b.weight);
        end else begin
            act = act_ring[ptr];
            act_ring[ptr] = '0;
            rd_ptr = (ptr + 1 >= span) ? 0 : ptr + 1;
            rise_x = q_sum(q_product(act, gain_x), q_product(rise_x, dec_x));
            cond_y = q_sum(q_product(rise_x, gain_y), q_product(cond_y, dec_y));
            r.cond    = q_product(cond_y, norm_g);
            r.current = q_product(q_diff(b.vm, rev_pot), r.cond);
            due_currents = {due_currents, r};
        end
    endfunction

    // Idle count for one beat; now and then a run of back-to-back beats.
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Signed random value with the given number of significant bits.
    function automatic dexs_pkg::t_q rand_q(int bits);
        dexs_pkg::t_q r;
        r = {$urandom, $urandom};
        return r >>> (64 - bits);
    endfunction

    function automatic logic [63:0] rand_u(int bits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r >> (64 - bits);
    endfunction

    // Input driver: beats leave the queue at the falling edge.
    always @(negedge i_clk) begin : beat_driver
        logic      v;
        t_syn_beat b;
        v = in_valid;
        if (in_taken) begin
            v = 1'b0;
        end
        if (!v && i_rst_n) begin
            if (in_wait > 0) begin
                in_wait--;
            end else if (synapse_beats.size() != 0) begin
                b = synapse_beats.pop_front();
                in_op     <= b.op;
                in_delay  <= b.delay;
                in_weight <= b.weight;
                in_vm     <= b.vm;
                v = 1'b1;
                in_wait = pick_wait(in_calm);
            end
        end
        in_valid <= v;
    end

    // A beat taken by the block updates the shadow state.
    always @(posedge i_clk) begin : beat_accept
        t_syn_beat b;
        in_taken <= i_rst_n && in_valid && in_ready;
        if (i_rst_n && in_valid && in_ready) begin
            b.op     = in_op;
            b.delay  = in_delay;
            b.weight = in_weight;
            b.vm     = in_vm;
            advance_synapse(b);
        end
    end

    // Result side back-pressure, redrawn after every result beat.
    always @(negedge i_clk) begin : result_stall
        int s;
        s = out_stall;
        if (out_taken) begin
            s = pick_wait(out_calm);
        end
        if (s > 0) begin
            out_ready <= 1'b0;
            s--;
        end else begin
            out_ready <= 1'b1;
        end
        out_stall = s;
    end

    // Result monitor: every beat against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_syn_out want;
        out_taken <= i_rst_n && out_valid && out_ready;
        if (i_rst_n && out_valid && out_ready) begin
            if (due_currents.size() == 0) begin
                $error("unexpected result beat: current_increment %h conductance %h",
                       out_current, out_cond);
                errors++;
            end else begin
                want = due_currents.pop_front();
                if (out_current !== want.current) begin
                    $error("current_increment: expected %h, got %h",
                           want.current, out_current);
                    errors++;
                end
                if (out_cond !== want.cond) begin
                    $error("conductance: expected %h, got %h", want.cond, out_cond);
                    errors++;
                end
            end
        end
    end

    // Register write; the shadow copy follows once the block takes it.
    task automatic cfg_write(dexs_pkg::t_cfg_idx idx, logic [63:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            dexs_pkg::CFG_INPUT_GAIN_X: gain_x = {1'b0, data[dexs_pkg::GAIN_W-1:0]};
            dexs_pkg::CFG_DECAY_X:
                dec_x = {{(64-dexs_pkg::DECAY_W){1'b0}}, data[dexs_pkg::DECAY_W-1:0]};
            dexs_pkg::CFG_INPUT_GAIN_Y: gain_y = {1'b0, data[dexs_pkg::GAIN_W-1:0]};
            dexs_pkg::CFG_DECAY_Y:
                dec_y = {{(64-dexs_pkg::DECAY_W){1'b0}}, data[dexs_pkg::DECAY_W-1:0]};
            dexs_pkg::CFG_REVERSAL:     rev_pot = data;
            dexs_pkg::CFG_PEAK_NORM:    norm_g = {1'b0, data[dexs_pkg::GAIN_W-1:0]};
            dexs_pkg::CFG_RING_LENGTH:  ring_len = data[dexs_pkg::RLEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_settings(logic [63:0] gx, logic [63:0] dx, logic [63:0] gy,
                                 logic [63:0] dy, logic [63:0] rev, logic [63:0] nrm,
                                 logic [63:0] len);
        cfg_write(dexs_pkg::CFG_INPUT_GAIN_X, gx);
        cfg_write(dexs_pkg::CFG_DECAY_X, dx);
        cfg_write(dexs_pkg::CFG_INPUT_GAIN_Y, gy);
        cfg_write(dexs_pkg::CFG_DECAY_Y, dy);
        cfg_write(dexs_pkg::CFG_REVERSAL, rev);
        cfg_write(dexs_pkg::CFG_PEAK_NORM, nrm);
        cfg_write(dexs_pkg::CFG_RING_LENGTH, len);
    endtask

    // Wait until every beat is sent and every result is back, then let a deposit finish.
    task automatic settle();
        while (synapse_beats.size() != 0 || in_valid || due_currents.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ITEM_TAIL) @(posedge i_clk);
    endtask

    function automatic void push_deposit(int delay, dexs_pkg::t_q w);
        t_syn_beat b;
        b.op     = dexs_pkg::OP_DEPOSIT;
        b.delay  = delay[dexs_pkg::DELAY_W-1:0];
        b.weight = w;
        b.vm     = rand_q(64);
        synapse_beats = {synapse_beats, b};
    endfunction

    function automatic void push_tick(dexs_pkg::t_q vm);
        t_syn_beat b;
        b.op     = dexs_pkg::OP_TICK;
        b.delay  = t_delay'(rand_u(dexs_pkg::DELAY_W));
        b.weight = rand_q(64);
        b.vm     = vm;
        synapse_beats = {synapse_beats, b};
    endfunction

    // Mostly modest values, sometimes full width, a rail or zero.
    function automatic dexs_pkg::t_q pick_value(int bits);
        case ($urandom_range(0, 9))
            0: return rand_q(64);
            1: return ($urandom_range(0, 2) == 0) ? dexs_pkg::Q_MAX :
                      ($urandom_range(0, 1) == 0) ? dexs_pkg::Q_MIN : dexs_pkg::t_q'(0);
            default: return rand_q(bits);
        endcase
    endfunction

    // Random beat: deposits land mostly just ahead of the read pointer.
    function automatic void push_random();
        int unsigned span;
        int          delay;
        span = ring_span();
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
                0:       delay = $urandom_range(0, 1023);
                1, 2:    delay = $urandom_range(0, span - 1);
                default: delay = $urandom_range(0, (span > 12) ? 12 : span - 1);
            endcase
            push_deposit(delay, pick_value(36));
        end else begin
            push_tick(pick_value(40));
        end
    endfunction

    // Settings for one random phase.
    task automatic pick_settings(int kind);
        logic [63:0] len;
        case (kind)
            0:       len = 64'(RING_SLOTS);
            1:       len = 64'($urandom_range(1, RING_SLOTS));
            2:       len = 64'd1;
            4:       len = 64'd2;
            default: len = 64'($urandom_range(3, 40));
        endcase
        case (kind)
            3: load_settings('1, '1, '1, '1, dexs_pkg::Q_MIN, '1, '1);
            5: load_settings('0, 64'h1_0000_0000, ONE_Q, 64'h1_0000_0000, dexs_pkg::Q_MAX,
                             ONE_Q, '0);
            6: load_settings(rand_u(64), rand_u(64), rand_u(64), rand_u(64), rand_u(64),
                             rand_u(64), rand_u(64));
            default: load_settings(rand_u(34), 64'h8000_0000 | rand_u(31), rand_u(34),
                                   64'h8000_0000 | rand_u(31), rand_q(40), rand_u(35), len);
        endcase
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        for (int i = 0; i < RING_SLOTS; i++) begin
            act_ring[i] = '0;
        end
        rd_ptr   = 0;
        rise_x   = '0;
        cond_y   = '0;
        gain_x   = '0;
        dec_x    = '0;
        gain_y   = '0;
        dec_y    = '0;
        rev_pot  = '0;
        norm_g   = '0;
        ring_len = dexs_pkg::RING_LENGTH_RST;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: the farthest slot of the full ring, zero gains.
        push_deposit(1023, dexs_pkg::Q_MAX);
        push_tick(dexs_pkg::Q_MAX);
        settle();

        // Eight-slot ring: slot sums saturate both ways, large delays wrap.
        load_settings(64'h1_8000_0000, 64'hC000_0000, 64'h8000_0000, 64'hE000_0000,
                      -64'sh46_0000_0000, 64'h2_0000_0000, 64'd8);
        push_deposit(0, dexs_pkg::Q_MAX);
        push_deposit(0, dexs_pkg::Q_MAX);
        push_deposit(1, dexs_pkg::Q_MIN);
        push_deposit(1, dexs_pkg::Q_MIN);
        push_deposit(9, ONE_Q);
        push_deposit(1023, -ONE_Q);
        push_tick(dexs_pkg::Q_MIN);
        push_tick(dexs_pkg::Q_MAX);
        push_tick('0);
        push_tick(-64'sh41_0000_0000);
        settle();

        // Ring shortened below the read pointer, which then restarts at zero.
        cfg_write(dexs_pkg::CFG_RING_LENGTH, 64'd2);
        push_deposit(1, 3 * ONE_Q);
        push_tick('0);
        push_tick('0);
        settle();

        // A zero length acts as one slot.
        cfg_write(dexs_pkg::CFG_RING_LENGTH, 64'd0);
        push_deposit(5, ONE_Q);
        push_tick(ONE_Q);
        settle();

        // A length beyond the ring acts as the whole ring.
        cfg_write(dexs_pkg::CFG_RING_LENGTH, '1);
        push_deposit(1023, -ONE_Q);
        push_tick(dexs_pkg::Q_MIN);
        settle();

        // Random phases, each under its own settings; every phase drains first.
        for (int ph = 0; ph < 8; ph++) begin
            pick_settings(ph);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                push_random();
            end
            settle();
        end

        if (due_currents.size() != 0) begin
            $error("%0d result beats never arrived", due_currents.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/dexs_pkg.sv
design/dexs_mul.sv
design/dexs_rem.sv
design/dexs_ring.sv
design/dual_exp_synapse_current_core.sv
test/dual_exp_synapse_current_core_test.sv
